/* hw/rtl/psd_pkg.sv */
// psd_pkg: shared types and constants of the point-to-segment distance block.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
package psd_pkg;

   localparam int COORD_W  = 16;
   localparam int DIST_W   = 33;
   localparam int REGION_W = 2;

   typedef enum logic [REGION_W-1:0] {
      REGION_INTERIOR = 2'd0,
      REGION_START    = 2'd1,
      REGION_END      = 2'd2
   } region_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0]   distance_q16;
      logic [REGION_W-1:0] closest_region;
   } rsp_type;

endpackage

/* hw/rtl/psd_front.sv */
// psd_front: differences, products, dot product, squared length and region.
// Depends on psd_pkg.
`timescale 1ns / 1ps
module psd_front import psd_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  req_type                        in_data,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [2*(COORD_BITS+1):0]      out_rem,
   output logic [2*(COORD_BITS+1)-1:0]    out_den,
   output logic [4*(COORD_BITS+1)+1:0]    out_side
);
   localparam int C  = COORD_BITS;
   localparam int DW = C + 1;
   localparam int PW = 2 * DW;
   localparam int N  = 4;

   logic [N-1:0] v_ff;
   logic [N:0]   adv;

   logic signed [C-1:0] px, py, ax, ay, bx, by;

   generate
      if (C <= COORD_W) begin : g_trim
         assign px = in_data.point_x[C-1:0];
         assign py = in_data.point_y[C-1:0];
         assign ax = in_data.start_x[C-1:0];
         assign ay = in_data.start_y[C-1:0];
         assign bx = in_data.end_x[C-1:0];
         assign by = in_data.end_y[C-1:0];
      end else begin : g_ext
         assign px = {{(C-COORD_W){in_data.point_x[COORD_W-1]}}, in_data.point_x};
         assign py = {{(C-COORD_W){in_data.point_y[COORD_W-1]}}, in_data.point_y};
         assign ax = {{(C-COORD_W){in_data.start_x[COORD_W-1]}}, in_data.start_x};
         assign ay = {{(C-COORD_W){in_data.start_y[COORD_W-1]}}, in_data.start_y};
         assign bx = {{(C-COORD_W){in_data.end_x[COORD_W-1]}}, in_data.end_x};
         assign by = {{(C-COORD_W){in_data.end_y[COORD_W-1]}}, in_data.end_y};
      end
   endgenerate

   // stage registers
   logic signed [DW-1:0] abx0_ff, aby0_ff, apx0_ff, apy0_ff;
   logic signed [DW-1:0] abx1_ff, aby1_ff, apx1_ff, apy1_ff;
   logic signed [DW-1:0] abx2_ff, aby2_ff, apx2_ff, apy2_ff;
   logic signed [DW-1:0] abx3_ff, aby3_ff, apx3_ff, apy3_ff;
   logic signed [PW-1:0] pxx_ff, pyy_ff, dxa_ff, dya_ff;
   logic [PW-1:0]        len2_ff, len2_3_ff;
   logic signed [PW:0]   dot_ff, dot_3_ff;
   logic [REGION_W-1:0]  region_ff;
   logic [REGION_W-1:0]  region_in;

   // bubble-collapsing advance chain
   assign adv[N] = out_ready;
   generate
      for (genvar i = 0; i < N; i++) begin : g_adv
         assign adv[i] = !v_ff[i] || adv[i+1];
      end
   endgenerate
   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= in_valid;
         if (adv[1]) v_ff[1] <= v_ff[0];
         if (adv[2]) v_ff[2] <= v_ff[1];
         if (adv[3]) v_ff[3] <= v_ff[2];
      end
   end

   always_comb begin
      if (dot_ff[PW] || dot_ff == '0 || len2_ff == '0) begin
         region_in = REGION_START;
      end else if ({1'b0, dot_ff[PW-1:0]} >= {1'b0, len2_ff}) begin
         region_in = REGION_END;
      end else begin
         region_in = REGION_INTERIOR;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         abx0_ff <= {bx[C-1], bx} - {ax[C-1], ax};
         aby0_ff <= {by[C-1], by} - {ay[C-1], ay};
         apx0_ff <= {px[C-1], px} - {ax[C-1], ax};
         apy0_ff <= {py[C-1], py} - {ay[C-1], ay};
      end
      if (adv[1]) begin
         pxx_ff  <= abx0_ff * abx0_ff;
         pyy_ff  <= aby0_ff * aby0_ff;
         dxa_ff  <= abx0_ff * apx0_ff;
         dya_ff  <= aby0_ff * apy0_ff;
         abx1_ff <= abx0_ff;
         aby1_ff <= aby0_ff;
         apx1_ff <= apx0_ff;
         apy1_ff <= apy0_ff;
      end
      if (adv[2]) begin
         len2_ff <= pxx_ff + pyy_ff;
         dot_ff  <= {dxa_ff[PW-1], dxa_ff} + {dya_ff[PW-1], dya_ff};
         abx2_ff <= abx1_ff;
         aby2_ff <= aby1_ff;
         apx2_ff <= apx1_ff;
         apy2_ff <= apy1_ff;
      end
      if (adv[3]) begin
         region_ff <= region_in;
         len2_3_ff <= len2_ff;
         dot_3_ff  <= dot_ff;
         abx3_ff   <= abx2_ff;
         aby3_ff   <= aby2_ff;
         apx3_ff   <= apx2_ff;
         apy3_ff   <= apy2_ff;
      end
   end

   assign out_valid = v_ff[N-1];
   assign out_rem   = dot_3_ff;
   assign out_den   = len2_3_ff;
   assign out_side  = {abx3_ff, aby3_ff, apx3_ff, apy3_ff, region_ff};

endmodule

/* hw/rtl/psd_div.sv */
// psd_div: restoring divider, one quotient bit per pipeline stage.
// Depends on psd_pkg.
`timescale 1ns / 1ps
module psd_div import psd_pkg::*; #(
   parameter int REM_W  = 35,
   parameter int QUO_W  = 16,
   parameter int SIDE_W = 70
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [REM_W-1:0]  in_rem,
   input  logic [REM_W-2:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);
   localparam int N = QUO_W;

   logic [N-1:0]      v_ff;
   logic [N:0]        adv;
   logic [REM_W-1:0]  rem_ff  [N];
   logic [REM_W-2:0]  den_ff  [N];
   logic [QUO_W-1:0]  quo_ff  [N];
   logic [SIDE_W-1:0] side_ff [N];

   assign adv[N]   = out_ready;
   assign in_ready = adv[0];

   generate
      for (genvar i = 0; i < N; i++) begin : g_stage
         logic              v_prev;
         logic [REM_W-1:0]  rem_prev;
         logic [REM_W-2:0]  den_prev;
         logic [QUO_W-1:0]  quo_prev;
         logic [SIDE_W-1:0] side_prev;
         logic [REM_W-1:0]  shifted;
         logic              take;

         if (i == 0) begin : g_first
            assign v_prev    = in_valid;
            assign rem_prev  = in_rem;
            assign den_prev  = in_den;
            assign quo_prev  = '0;
            assign side_prev = in_side;
         end else begin : g_next
            assign v_prev    = v_ff[i-1];
            assign rem_prev  = rem_ff[i-1];
            assign den_prev  = den_ff[i-1];
            assign quo_prev  = quo_ff[i-1];
            assign side_prev = side_ff[i-1];
         end

         assign adv[i]  = !v_ff[i] || adv[i+1];
         assign shifted = {rem_prev[REM_W-2:0], 1'b0};
         assign take    = shifted >= {1'b0, den_prev};

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[i] <= 1'b0;
            end else if (adv[i]) begin
               v_ff[i] <= v_prev;
            end
         end

         always_ff @(posedge clock) begin
            if (adv[i]) begin
               rem_ff[i]  <= take ? shifted - {1'b0, den_prev} : shifted;
               den_ff[i]  <= den_prev;
               quo_ff[i]  <= {quo_prev[QUO_W-2:0], take};
               side_ff[i] <= side_prev;
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[N-1];
   assign out_quo   = quo_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

/* hw/rtl/psd_offset.sv */
// psd_offset: clamped ratio, offset vector and its squared length.
// Depends on psd_pkg.
`timescale 1ns / 1ps
module psd_offset import psd_pkg::*; #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [FRAC_BITS-1:0]                   in_quo,
   input  logic [4*(COORD_BITS+1)+1:0]            in_side,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [2*(FRAC_BITS+COORD_BITS+2):0]    out_sum,
   output logic [REGION_W-1:0]                    out_region
);
   localparam int C    = COORD_BITS;
   localparam int F    = FRAC_BITS;
   localparam int DW   = C + 1;
   localparam int OW   = F + C + 3;
   localparam int MW   = OW - 1;
   localparam int LO_W = (MW + 1) / 2;
   localparam int HI_W = MW - LO_W;
   localparam int N    = 7;

   logic [N-1:0] v_ff;
   logic [N:0]   adv;

   logic signed [DW-1:0] abx_in, aby_in, apx_in, apy_in;
   logic [REGION_W-1:0]  region_in;
   logic [F:0]           t_in;

   assign {abx_in, aby_in, apx_in, apy_in, region_in} = in_side;

   always_comb begin
      case (region_in)
         REGION_INTERIOR: t_in = {1'b0, in_quo};
         REGION_END:      t_in = {1'b1, {F{1'b0}}};
         default:         t_in = '0;
      endcase
   end

   logic [F:0]              t_ff;
   logic signed [DW-1:0]    abx_ff, aby_ff, apx0_ff, apy0_ff, apx1_ff, apy1_ff;
   logic signed [OW-1:0]    tx_ff, ty_ff, ox_ff, oy_ff;
   logic [MW-1:0]           mx_ff, my_ff;
   logic [2*HI_W-1:0]       hhx_ff, hhy_ff;
   logic [HI_W+LO_W-1:0]    hlx_ff, hly_ff;
   logic [2*LO_W-1:0]       llx_ff, lly_ff;
   logic [2*MW-1:0]         sqx_ff, sqy_ff;
   logic [2*MW:0]           sum_ff;
   logic [REGION_W-1:0]     reg_ff [N];

   logic signed [OW-1:0]    ox_in, oy_in;
   logic [MW-1:0]           mx_in, my_in;

   assign adv[N] = out_ready;
   generate
      for (genvar i = 0; i < N; i++) begin : g_adv
         assign adv[i] = !v_ff[i] || adv[i+1];
      end
   endgenerate
   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < N; i++) begin
            if (adv[i]) v_ff[i] <= (i == 0) ? in_valid : v_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   assign ox_in = tx_ff - {{2{apx1_ff[DW-1]}}, apx1_ff, {F{1'b0}}};
   assign oy_in = ty_ff - {{2{apy1_ff[DW-1]}}, apy1_ff, {F{1'b0}}};
   assign mx_in = ox_ff[OW-1] ? MW'(-ox_ff) : ox_ff[MW-1:0];
   assign my_in = oy_ff[OW-1] ? MW'(-oy_ff) : oy_ff[MW-1:0];

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         t_ff      <= t_in;
         abx_ff    <= abx_in;
         aby_ff    <= aby_in;
         apx0_ff   <= apx_in;
         apy0_ff   <= apy_in;
         reg_ff[0] <= region_in;
      end
      if (adv[1]) begin
         tx_ff     <= $signed({1'b0, t_ff}) * abx_ff;
         ty_ff     <= $signed({1'b0, t_ff}) * aby_ff;
         apx1_ff   <= apx0_ff;
         apy1_ff   <= apy0_ff;
         reg_ff[1] <= reg_ff[0];
      end
      if (adv[2]) begin
         ox_ff     <= ox_in;
         oy_ff     <= oy_in;
         reg_ff[2] <= reg_ff[1];
      end
      if (adv[3]) begin
         mx_ff     <= mx_in;
         my_ff     <= my_in;
         reg_ff[3] <= reg_ff[2];
      end
      // split each magnitude into halves to keep the multipliers narrow
      if (adv[4]) begin
         hhx_ff    <= mx_ff[MW-1:LO_W] * mx_ff[MW-1:LO_W];
         hlx_ff    <= mx_ff[MW-1:LO_W] * mx_ff[LO_W-1:0];
         llx_ff    <= mx_ff[LO_W-1:0] * mx_ff[LO_W-1:0];
         hhy_ff    <= my_ff[MW-1:LO_W] * my_ff[MW-1:LO_W];
         hly_ff    <= my_ff[MW-1:LO_W] * my_ff[LO_W-1:0];
         lly_ff    <= my_ff[LO_W-1:0] * my_ff[LO_W-1:0];
         reg_ff[4] <= reg_ff[3];
      end
      if (adv[5]) begin
         sqx_ff <= ({{(2*LO_W){1'b0}}, hhx_ff} << (2*LO_W))
                 + ({{MW{1'b0}}, hlx_ff} << (LO_W + 1))
                 + {{(2*HI_W){1'b0}}, llx_ff};
         sqy_ff <= ({{(2*LO_W){1'b0}}, hhy_ff} << (2*LO_W))
                 + ({{MW{1'b0}}, hly_ff} << (LO_W + 1))
                 + {{(2*HI_W){1'b0}}, lly_ff};
         reg_ff[5] <= reg_ff[4];
      end
      if (adv[6]) begin
         sum_ff    <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
         reg_ff[6] <= reg_ff[5];
      end
   end

   assign out_valid  = v_ff[N-1];
   assign out_sum    = sum_ff;
   assign out_region = reg_ff[N-1];

endmodule

/* hw/rtl/psd_sqrt.sv */
// psd_sqrt: digit-by-digit integer square root, one root bit per stage.
// Depends on psd_pkg.
`timescale 1ns / 1ps
module psd_sqrt import psd_pkg::*; #(
   parameter int RAD_W = 69
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [RAD_W-1:0]                 in_rad,
   input  logic [REGION_W-1:0]              in_region,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [(RAD_W+1)/2-1:0]           out_root,
   output logic [REGION_W-1:0]              out_region
);
   localparam int PW  = 2 * ((RAD_W + 1) / 2);
   localparam int R   = PW / 2;
   localparam int RMW = R + 3;
   localparam int N   = R;

   logic [N-1:0]        v_ff;
   logic [N:0]          adv;
   logic [RMW-1:0]      rem_ff  [N];
   logic [R-1:0]        root_ff [N];
   logic [PW-1:0]       rad_ff  [N];
   logic [REGION_W-1:0] reg_ff  [N];

   assign adv[N]   = out_ready;
   assign in_ready = adv[0];

   generate
      for (genvar i = 0; i < N; i++) begin : g_stage
         logic                v_prev;
         logic [RMW-1:0]      rem_prev;
         logic [R-1:0]        root_prev;
         logic [PW-1:0]       rad_prev;
         logic [REGION_W-1:0] reg_prev;
         logic [RMW-1:0]      cur;
         logic [RMW-1:0]      trial;
         logic                take;

         if (i == 0) begin : g_first
            assign v_prev    = in_valid;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = PW'(in_rad);
            assign reg_prev  = in_region;
         end else begin : g_next
            assign v_prev    = v_ff[i-1];
            assign rem_prev  = rem_ff[i-1];
            assign root_prev = root_ff[i-1];
            assign rad_prev  = rad_ff[i-1];
            assign reg_prev  = reg_ff[i-1];
         end

         assign adv[i] = !v_ff[i] || adv[i+1];
         assign cur    = {rem_prev[RMW-3:0], rad_prev[PW-1:PW-2]};
         assign trial  = {1'b0, root_prev, 2'b01};
         assign take   = cur >= trial;

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[i] <= 1'b0;
            end else if (adv[i]) begin
               v_ff[i] <= v_prev;
            end
         end

         always_ff @(posedge clock) begin
            if (adv[i]) begin
               rem_ff[i]  <= take ? cur - trial : cur;
               root_ff[i] <= {root_prev[R-2:0], take};
               rad_ff[i]  <= {rad_prev[PW-3:0], 2'b00};
               reg_ff[i]  <= reg_prev;
            end
         end
      end
   endgenerate

   assign out_valid  = v_ff[N-1];
   assign out_root   = root_ff[N-1];
   assign out_region = reg_ff[N-1];

endmodule

/* hw/rtl/point_segment_distance.sv */
// point_segment_distance: top level, chains front end, divider, offset and root.
// Depends on psd_pkg, psd_front, psd_div, psd_offset and psd_sqrt.
`timescale 1ns / 1ps
//
// Distance from a point P to the segment A-B, all coordinates signed integers.
// Requests arrive on req_valid/req_ready/req_data, results leave on
// rsp_valid/rsp_ready/rsp_data, one result per request, in request order.
// Each result carries the floor of the distance in Q17.16 and the region of
// the closest point: interior, clamped to start (or degenerate), clamped to end.
//
// Throughput: one request per cycle, sustained while rsp_ready stays high.
// The divider (one quotient bit per stage) and the root unit (one root bit per
// stage) make up most of the pipeline depth.
//
// Every stage carries its own valid bit; a stage takes new data when it is
// empty or when the stage after it moves, so bubbles collapse and requests
// keep entering while a stalled receiver holds a result, until all stages fill.
// Stall: hold every full stage whose successor cannot move; nothing is lost.
// Reset clears all valid bits; the block is ready for a request once reset is released.
// Distances wider than 33 bits saturate; at the default sizes none occur.
//
module point_segment_distance import psd_pkg::*; #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   localparam int DW     = COORD_BITS + 1;
   localparam int REM_W  = 2 * DW + 1;
   localparam int SIDE_W = 4 * DW + REGION_W;
   localparam int MW     = FRAC_BITS + COORD_BITS + 2;
   localparam int SQ_W   = 2 * MW + 1;
   localparam int ROOT_W = (SQ_W + 1) / 2;

   // front end -> divider
   logic              fr_valid, fr_ready;
   logic [REM_W-1:0]  fr_rem;
   logic [REM_W-2:0]  fr_den;
   logic [SIDE_W-1:0] fr_side;

   // divider -> offset
   logic                 dv_valid, dv_ready;
   logic [FRAC_BITS-1:0] dv_quo;
   logic [SIDE_W-1:0]    dv_side;

   // offset -> root
   logic                of_valid, of_ready;
   logic [SQ_W-1:0]     of_sum;
   logic [REGION_W-1:0] of_region;

   // root output
   logic [ROOT_W-1:0]   sq_root;
   logic [REGION_W-1:0] sq_region;

   psd_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_rem   (fr_rem),
      .out_den   (fr_den),
      .out_side  (fr_side)
   );

   psd_div #(
      .REM_W  (REM_W),
      .QUO_W  (FRAC_BITS),
      .SIDE_W (SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_rem    (fr_rem),
      .in_den    (fr_den),
      .in_side   (fr_side),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   psd_offset #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_offset (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (dv_valid),
      .in_ready   (dv_ready),
      .in_quo     (dv_quo),
      .in_side    (dv_side),
      .out_valid  (of_valid),
      .out_ready  (of_ready),
      .out_sum    (of_sum),
      .out_region (of_region)
   );

   psd_sqrt #(
      .RAD_W (SQ_W)
   ) u_sqrt (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (of_valid),
      .in_ready   (of_ready),
      .in_rad     (of_sum),
      .in_region  (of_region),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_root   (sq_root),
      .out_region (sq_region)
   );

   // saturate the root to the result width where it can be wider
   generate
      if (ROOT_W > DIST_W) begin : g_sat
         assign rsp_data.distance_q16 = (|sq_root[ROOT_W-1:DIST_W]) ? {DIST_W{1'b1}}
                                                                    : sq_root[DIST_W-1:0];
      end else begin : g_ext
         assign rsp_data.distance_q16 = DIST_W'(sq_root);
      end
   endgenerate

   assign rsp_data.closest_region = sq_region;

endmodule

/* hw/rtl/psd_checker.sv */
// psd_checker: port-level checks of point_segment_distance, bound to the top.
// Depends on psd_pkg and point_segment_distance.
`timescale 1ns / 1ps
module psd_checker import psd_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // region code three is never produced
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.closest_region != 2'd3)
      else $error("invalid region code");

   // an empty output stage means the pipeline has room
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with empty output");

   // a draining output frees every stage
   assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request refused while output drains");

   // no result right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind point_segment_distance psd_checker u_checker (.*);

/* tb/psd_checker.sv */
// psd_scoreboard: watches both channels of point_segment_distance, predicts each result
// and compares it with what the block returns. Depends on psd_pkg.
`timescale 1ns / 1ps
module psd_scoreboard import psd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count,
   output int      rsp_count
);

   rsp_type expected_rsps[$];

   // Floor square root of a value up to 66 bits, one root bit at a time.
   function automatic logic [32:0] root_floor(input logic [65:0] v);
      logic [33:0]  r;
      logic [33:0]  c;
      logic [67:0]  sq;
      r = '0;
      for (int i = 33; i >= 0; i--) begin
         c  = r | (34'd1 << i);
         sq = {34'd0, c} * {34'd0, c};
         if (sq <= {2'b00, v}) r = c;
      end
      if (r > 34'h1_FFFF_FFFF) r = 34'h1_FFFF_FFFF;
      return r[32:0];
   endfunction

   function automatic rsp_type distance_of(input req_type q);
      logic signed [63:0] abx, aby, apx, apy, len2, dot, t, ox, oy;
      logic [63:0]        rem, quo, mx, my;
      rsp_type            o;
      abx  = 64'(q.end_x) - 64'(q.start_x);
      aby  = 64'(q.end_y) - 64'(q.start_y);
      apx  = 64'(q.point_x) - 64'(q.start_x);
      apy  = 64'(q.point_y) - 64'(q.start_y);
      len2 = abx * abx + aby * aby;
      dot  = abx * apx + aby * apy;
      if (dot <= 0 || len2 == 0) begin
         t = 0;
         o.closest_region = REGION_START;
      end else if (dot >= len2) begin
         t = 64'sd65536;
         o.closest_region = REGION_END;
      end else begin
         rem = dot;
         quo = 0;
         for (int i = 0; i < 16; i++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= 64'(len2)) begin
               rem = rem - 64'(len2);
               quo[0] = 1'b1;
            end
         end
         t = quo;
         o.closest_region = REGION_INTERIOR;
      end
      ox = t * abx - apx * 64'sd65536;
      oy = t * aby - apy * 64'sd65536;
      mx = ox < 0 ? -ox : ox;
      my = oy < 0 ? -oy : oy;
      o.distance_q16 = root_floor(66'(mx) * 66'(mx) + 66'(my) * 66'(my));
      return o;
   endfunction

   assign pending_count = expected_rsps.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fail_count <= 0;
         rsp_count  <= 0;
      end else begin
         if (req_valid && req_ready) expected_rsps.push_back(distance_of(req_data));
         if (rsp_valid && rsp_ready) begin
            rsp_count <= rsp_count + 1;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (want.distance_q16 !== rsp_data.distance_q16 ||
                   want.closest_region !== rsp_data.closest_region) begin
                  $display("%0t: mismatch expected dist %0d region %0d, %s %0d region %0d",
                           $time, want.distance_q16, want.closest_region, "actual dist",
                           rsp_data.distance_q16, rsp_data.closest_region);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

/* tb/tb_point_segment_distance.sv */
// tb_point_segment_distance: drives requests into point_segment_distance under varying
// back-pressure, reports the verdict. Depends on psd_pkg, the DUT and psd_scoreboard.
`timescale 1ns / 1ps
module tb_point_segment_distance;
   import psd_pkg::*;

   localparam int LATENCY   = 62;
   localparam int WDOG_MAX  = 4000;
   localparam int N_RANDOM  = 630;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      fail_count, pending_count, rsp_count;

   // Idle percentages for the sender and receiver, changed by phase.
   int      send_idle = 26;
   int      recv_idle = 50;
   int      req_total = 0;
   int      stall_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   point_segment_distance dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   psd_scoreboard checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .fail_count, .pending_count, .rsp_count
   );

   // Receiver: drop ready at random according to the current phase.
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else       rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   // Watchdog: count cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else if (req_valid || pending_count != 0) stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WDOG_MAX) begin
         $display("watchdog: no handshake for %0d cycles", WDOG_MAX);
         $display("** point_segment_distance: FAILED **");
         $finish;
      end
   end

   function automatic logic signed [15:0] coord_rand();
      case ($urandom_range(7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'(int'($urandom_range(16)) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   // Present one request, hold it until accepted, then maybe idle.
   task automatic send_req(input req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      req_total++;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_pts(input int px, py, ax, ay, bx, by);
      req_type r;
      r.point_x = 16'(px); r.point_y = 16'(py);
      r.start_x = 16'(ax); r.start_y = 16'(ay);
      r.end_x   = 16'(bx); r.end_y   = 16'(by);
      send_req(r);
   endtask

   task automatic random_phase(input int count);
      req_type r;
      int      kind;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(9);
         r.start_x = coord_rand(); r.start_y = coord_rand();
         r.end_x   = coord_rand(); r.end_y   = coord_rand();
         r.point_x = coord_rand(); r.point_y = coord_rand();
         if (kind == 0) begin
            // degenerate segment
            r.end_x = r.start_x; r.end_y = r.start_y;
         end else if (kind < 5) begin
            // point near the segment so interior projections dominate
            r.point_x = r.start_x + (r.end_x - r.start_x) / 2
                      + $signed(16'($urandom_range(200))) - 16'sd100;
            r.point_y = r.start_y + (r.end_y - r.start_y) / 2
                      + $signed(16'($urandom_range(200))) - 16'sd100;
         end
         send_req(r);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, degenerate, each region, tiny interior ratios.
      send_pts(0, 0, 0, 0, 0, 0);
      send_pts(5, 7, 3, 3, 3, 3);
      send_pts(32767, 32767, -32768, -32768, -32768, -32768);
      send_pts(-32768, -32768, 32767, 32767, 32767, 32767);
      send_pts(32767, -32768, -32768, 32767, 32767, -32768);
      send_pts(-32768, 32767, -32768, -32768, 32767, 32767);
      send_pts(32767, 32767, -32768, -32768, 32767, 32767);
      send_pts(-32768, -32768, -32768, -32768, 32767, 32767);
      send_pts(0, 32767, -32768, 0, 32767, 0);
      send_pts(0, -32768, -32768, -32768, 32767, 32767);
      send_pts(-5, 3, 0, 0, 10, 0);
      send_pts(15, 3, 0, 0, 10, 0);
      send_pts(10, 3, 0, 0, 10, 0);
      send_pts(4, 3, 0, 0, 10, 0);
      send_pts(1, 0, -32768, -32768, 32767, 32767);
      send_pts(-32767, 32767, -32768, -32768, 32767, 32767);
      send_pts(1, 1, 0, 0, 32767, -32768);
      send_pts(-1, -1, 0, 0, 1, 1);
      send_pts(1, 0, 0, 0, 1, 1);
      send_pts(0, 5, 0, 0, 0, 10);

      random_phase(N_RANDOM / 3);
      send_idle = 50; recv_idle = 26;
      random_phase(N_RANDOM / 3);
      send_idle = 0;  recv_idle = 0;
      random_phase(N_RANDOM / 3);
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      $display("sent %0d requests covering all regions, degenerate and extreme segments;",
               req_total);
      $display("checked %0d responses under three back-pressure mixes", rsp_count);
      if (fail_count == 0 && pending_count == 0)
         $display("** point_segment_distance: PASSED **");
      else
         $display("** point_segment_distance: FAILED **");
      $finish;
   end

endmodule
